/* rtl/core/pva_pkg.sv */
// pva_pkg: widths, limits and codes for the two-ended palette allocator
// no dependencies; used by palette_vram_two_ended_allocator
`default_nettype none

package pva_pkg;

  localparam int ADDRESS_BITS = 19;
  localparam int AMOUNT_BITS  = 20;
  // a rounded size below the limit always fits here
  localparam int SIZE_BITS    = 19;
  localparam int CFG_BITS     = 19;
  localparam int HANDLE_BITS  = 32;

  localparam logic [ADDRESS_BITS-1:0] DEFAULT_END = ADDRESS_BITS'(98304);
  localparam logic [AMOUNT_BITS:0]    SIZE_LIMIT  = (AMOUNT_BITS+1)'('h7fff8);
  localparam logic [SIZE_BITS:0]      EIGHT_LIMIT = (SIZE_BITS+1)'('h10000);

  // command codes
  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_RELOAD = 1'b1;

  // configuration register indexes
  localparam logic CFG_POOL_START = 1'b0;
  localparam logic CFG_POOL_END   = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/palette_vram_two_ended_allocator.sv */
// palette_vram_two_ended_allocator: front/back bump allocator over one region
// depends on pva_pkg
//
//   channel | signals                                            | dir
//   in      | in_valid, in_stall, command, amount,               | in (stall out)
//           | eight_byte_align, from_front                       |
//   out     | out_valid, out_stall, handle, granted              | out (stall in)
//   cfg     | cfg_write, cfg_index, cfg_data                     | in
//
// one item per cycle while in_stall is low; each result is registered.
// the pointers are updated at the accept edge, so the next item sees them at once.
// a two-entry output buffer (result register plus skid register) lets an item
// be accepted while a result waits; in_stall rises only when both are full.
// rst (synchronous) restores bounds 0 / 98304 and both pointers, empties the buffer.
`default_nettype none

module palette_vram_two_ended_allocator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic                                cfg_index,
  input  wire logic [pva_pkg::CFG_BITS-1:0]        cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                command,
  input  wire logic [pva_pkg::AMOUNT_BITS-1:0]     amount,
  input  wire logic                                eight_byte_align,
  input  wire logic                                from_front,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [pva_pkg::HANDLE_BITS-1:0]          handle,
  output logic                                     granted
);

  localparam int AW = pva_pkg::ADDRESS_BITS;
  localparam int SW = pva_pkg::SIZE_BITS;
  localparam int ZW = pva_pkg::AMOUNT_BITS + 1;

  logic [AW-1:0] pool_start;
  logic [AW-1:0] pool_end;
  logic [AW-1:0] front_pointer;
  logic [AW-1:0] back_pointer;

  logic                               skid_valid;
  logic [pva_pkg::HANDLE_BITS-1:0]    skid_handle;
  logic                               skid_granted;

  logic accept;
  logic take;

  // allocation datapath
  logic [ZW-1:0] size;        // rounded size, may exceed the limit
  logic [SW-1:0] size_n;      // in range once not oversize
  logic          oversize;
  logic [AW-1:0] freesp;
  logic [3:0]    front_pad;
  logic [SW:0]   front_total;
  logic [SW:0]   front_next;
  logic [SW:0]   front_pos;
  logic          front_ok;
  logic [AW-1:0] below;
  logic [3:0]    back_pad;
  logic [SW:0]   back_total;
  logic [AW-1:0] back_pos;
  logic          back_ok;
  logic          ok;
  logic [AW-1:0] pos;
  logic [pva_pkg::HANDLE_BITS-1:0] res_handle;
  logic [AW-1:0] front_pointer_next;
  logic [AW-1:0] back_pointer_next;

  always_comb begin
    if (amount == '0) begin
      size = ZW'(8);
    end else begin
      size = (ZW'(amount) + ZW'(7)) & ~ZW'(7);
    end
    oversize = (size >= pva_pkg::SIZE_LIMIT);
    size_n   = size[SW-1:0];
    freesp   = (back_pointer >= front_pointer) ? (back_pointer - front_pointer) : '0;

    // front side: pad up to the alignment, then advance
    if (eight_byte_align) begin
      front_pad = {1'b0, 3'(4'd8 - {1'b0, front_pointer[2:0]})};
    end else begin
      front_pad = 4'(5'd16 - {1'b0, front_pointer[3:0]});
    end
    front_total = (SW+1)'(size_n) + (SW+1)'(front_pad);
    front_next  = (SW+1)'(front_pointer) + front_total;
    front_pos   = (SW+1)'(front_pointer) + (SW+1)'(front_pad);
    front_ok    = ((SW+1)'(freesp) >= front_total) &&
                  !(eight_byte_align && (front_next > pva_pkg::EIGHT_LIMIT));

    // back side: drop below the block to an aligned spot
    below      = back_pointer - size_n[AW-1:0];
    back_pad   = eight_byte_align ? {1'b0, below[2:0]} : below[3:0];
    back_total = (SW+1)'(size_n) + (SW+1)'(back_pad);
    back_pos   = back_pointer - back_total[AW-1:0];
    back_ok    = (SW'(back_pointer) >= size_n) && ((SW+1)'(freesp) >= back_total) &&
                 !(eight_byte_align && ((SW+1)'(back_pointer) > pva_pkg::EIGHT_LIMIT));

    ok  = (command == pva_pkg::CMD_ALLOC) && !oversize && (from_front ? front_ok : back_ok);
    pos = from_front ? front_pos[AW-1:0] : back_pos;

    res_handle = '0;
    if (ok) begin
      res_handle = {16'(size_n >> 3), 16'(pos >> 3)};
    end

    front_pointer_next = front_pointer;
    back_pointer_next  = back_pointer;
    if (command == pva_pkg::CMD_RELOAD) begin
      front_pointer_next = pool_start;
      back_pointer_next  = pool_end;
    end else if (ok && from_front) begin
      front_pointer_next = front_next[AW-1:0];
    end else if (ok) begin
      back_pointer_next = back_pos;
    end
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  // configuration and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_start    <= '0;
      pool_end      <= pva_pkg::DEFAULT_END;
      front_pointer <= '0;
      back_pointer  <= pva_pkg::DEFAULT_END;
    end else begin
      if (cfg_write && cfg_index == pva_pkg::CFG_POOL_START) begin
        pool_start <= cfg_data[AW-1:0];
      end
      if (cfg_write && cfg_index == pva_pkg::CFG_POOL_END) begin
        pool_end <= cfg_data[AW-1:0];
      end
      if (accept) begin
        front_pointer <= front_pointer_next;
        back_pointer  <= back_pointer_next;
      end
    end
  end

  // output buffer: result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= skid_valid && accept;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        handle  <= skid_handle;
        granted <= skid_granted;
      end else if (accept) begin
        handle  <= res_handle;
        granted <= ok;
      end
      if (skid_valid && accept) begin
        skid_handle  <= res_handle;
        skid_granted <= ok;
      end
    end else if (accept) begin
      skid_handle  <= res_handle;
      skid_granted <= ok;
    end
  end

endmodule

`default_nettype wire
